### design/bai_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bai_pkg - shared definitions of the bitmap attribute index
// Field widths, request kinds, default sizes and the command and status
// groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package bai_pkg;

	localparam int KIND_W = 2;
	localparam int VID_W  = 6;
	localparam int ATTR_W = 8;

	localparam logic [KIND_W-1:0] KIND_SET  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLR  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TERM = 2'd2;

	localparam int VECTORS_DEF    = 64;
	localparam int ATTRIBUTES_DEF = 256;

	typedef struct packed {
		logic accept;
		logic exec;
		logic clear_step;
		logic emit_load;
	} bai_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic emit_needed;
		logic emit_last;
	} bai_status_t;

endpackage
`default_nettype wire

### design/bai_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bai_if - request and result channels of the bitmap attribute index
// Valid/ready channels; a request or result moves when both are high.
// ----------------------------------------------------------------------------
interface bai_item_if
	import bai_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [VID_W-1:0]  vector_id;
	logic [ATTR_W-1:0] attribute;
	logic              or_inside;
	logic              group_end;
	logic              query_end;

	modport source (output valid, kind, vector_id, attribute, or_inside, group_end,
		query_end, input ready);
	modport sink (input valid, kind, vector_id, attribute, or_inside, group_end,
		query_end, output ready);
endinterface

interface bai_result_if
	import bai_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [VID_W-1:0] match_id;
	logic             found;
	logic             last;

	modport source (output valid, match_id, found, last, input ready);
	modport sink (input valid, match_id, found, last, output ready);
endinterface
`default_nettype wire

### design/bai_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bai_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bai_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### design/bai_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bai_dp - datapath of the bitmap attribute index
// Row store with known flags, request capture, group and query combine,
// match scan and result register.
// ----------------------------------------------------------------------------
module bai_dp
	import bai_pkg::*;
#(
	parameter int VECTORS    = VECTORS_DEF,
	parameter int ATTRIBUTES = ATTRIBUTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bai_cmd_t          cmd,
	output bai_status_t            status,
	input  wire logic [KIND_W-1:0] kind,
	input  wire logic [VID_W-1:0]  vector_id,
	input  wire logic [ATTR_W-1:0] attribute,
	input  wire logic              or_inside,
	input  wire logic              group_end,
	input  wire logic              query_end,
	output logic      [VID_W-1:0]  match_id,
	output logic                   found,
	output logic                   last
);

	localparam int AW = $clog2(ATTRIBUTES);
	localparam int XW = (AW > ATTR_W) ? AW : ATTR_W;
	localparam int WW = VECTORS + 1;

	logic [XW-1:0]      attr_x;
	logic [AW-1:0]      raddr;
	logic [WW-1:0]      rdata;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [WW-1:0]      wdata;

	logic [AW-1:0]      clr_addr_q;
	logic [KIND_W-1:0]  kind_q;
	logic [VID_W-1:0]   vid_q;
	logic [AW-1:0]      addr_q;
	logic               vid_ok_q;
	logic               attr_ok_q;
	logic               or_q;
	logic               gend_q;
	logic               qend_q;

	logic [VECTORS-1:0] g_acc_q;
	logic               g_has_q;
	logic               g_killed_q;
	logic [VECTORS-1:0] q_acc_q;
	logic               q_started_q;
	logic               q_dead_q;
	logic [VECTORS-1:0] hits_q;
	logic [VID_W-1:0]   match_id_q;
	logic               found_q;
	logic               last_q;

	logic [VECTORS-1:0] row;
	logic               mem_known;
	logic               known;
	logic [VECTORS-1:0] vbit;
	logic               wr_ok;
	logic [VECTORS-1:0] g_acc_n;
	logic               g_has_n;
	logic               g_killed_n;
	logic [VECTORS-1:0] q_acc_n;
	logic               q_started_n;
	logic               q_dead_n;
	logic [VECTORS-1:0] hits_n;
	logic [VECTORS-1:0] hits_rest;
	logic [VID_W-1:0]   first_id;

	assign attr_x = XW'(attribute);
	assign raddr  = attr_x[AW-1:0];

	bai_ram #(
		.WIDTH (WW),
		.DEPTH (ATTRIBUTES)
	) u_rows (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.accept),
		.raddr (raddr),
		.rdata (rdata)
	);

	// capture the request alongside the row read
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q    <= kind;
			vid_q     <= vector_id;
			addr_q    <= raddr;
			vid_ok_q  <= ({1'b0, vector_id} < (VID_W + 1)'(VECTORS));
			attr_ok_q <= (32'(attribute) < 32'(ATTRIBUTES));
			or_q      <= or_inside;
			gend_q    <= group_end;
			qend_q    <= query_end;
		end
	end

	assign row       = rdata[VECTORS-1:0];
	assign mem_known = rdata[VECTORS];
	assign known     = mem_known & attr_ok_q;
	assign vbit      = VECTORS'(1) << vid_q;
	assign wr_ok     = vid_ok_q && attr_ok_q &&
		((kind_q == KIND_SET) || ((kind_q == KIND_CLR) && mem_known));

	always_comb begin
		we    = cmd.clear_step || (cmd.exec && wr_ok);
		waddr = cmd.clear_step ? clr_addr_q : addr_q;
		if (cmd.clear_step) begin
			wdata = '0;
		end else if (kind_q == KIND_SET) begin
			wdata = {1'b1, row | vbit};
		end else begin
			wdata = {1'b1, row & ~vbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// fold the term into its group, then the group into the query
	always_comb begin
		g_acc_n     = g_acc_q;
		g_has_n     = g_has_q;
		g_killed_n  = g_killed_q;
		q_acc_n     = q_acc_q;
		q_started_n = q_started_q;
		q_dead_n    = q_dead_q;
		if (!or_q) begin
			if (!known) begin
				g_killed_n = 1'b1;
			end else if (!g_has_q) begin
				g_acc_n = row;
				g_has_n = 1'b1;
			end else begin
				g_acc_n = g_acc_q & row;
			end
		end else if (known) begin
			g_acc_n = g_has_q ? (g_acc_q | row) : row;
			g_has_n = 1'b1;
		end
		if (!or_q) begin
			if (!g_killed_n && g_has_n) begin
				q_acc_n = q_acc_q | g_acc_n;
			end
		end else if (!g_has_n) begin
			q_dead_n = 1'b1;
		end else if (!q_started_q) begin
			q_acc_n = g_acc_n;
		end else begin
			q_acc_n = q_acc_q & g_acc_n;
		end
		q_started_n = 1'b1;
		hits_n      = q_dead_n ? '0 : q_acc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_acc_q     <= '0;
			g_has_q     <= 1'b0;
			g_killed_q  <= 1'b0;
			q_acc_q     <= '0;
			q_started_q <= 1'b0;
			q_dead_q    <= 1'b0;
		end else if (cmd.exec && (kind_q == KIND_TERM)) begin
			if (qend_q) begin
				g_acc_q     <= '0;
				g_has_q     <= 1'b0;
				g_killed_q  <= 1'b0;
				q_acc_q     <= '0;
				q_started_q <= 1'b0;
				q_dead_q    <= 1'b0;
			end else if (gend_q) begin
				g_acc_q     <= '0;
				g_has_q     <= 1'b0;
				g_killed_q  <= 1'b0;
				q_acc_q     <= q_acc_n;
				q_started_q <= q_started_n;
				q_dead_q    <= q_dead_n;
			end else begin
				g_acc_q    <= g_acc_n;
				g_has_q    <= g_has_n;
				g_killed_q <= g_killed_n;
			end
		end
	end

	// lowest pending id first
	always_comb begin
		first_id = '0;
		for (int i = VECTORS - 1; i >= 0; i--) begin
			if (hits_q[i]) begin
				first_id = VID_W'(i);
			end
		end
	end

	assign hits_rest = hits_q & (hits_q - VECTORS'(1));

	always_ff @(posedge clk) begin
		if (cmd.exec && (kind_q == KIND_TERM) && qend_q) begin
			hits_q <= hits_n;
		end else if (cmd.emit_load) begin
			hits_q <= hits_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			if (hits_q != '0) begin
				match_id_q <= first_id;
				found_q    <= 1'b1;
				last_q     <= (hits_rest == '0);
			end else begin
				match_id_q <= '0;
				found_q    <= 1'b0;
				last_q     <= 1'b1;
			end
		end
	end

	assign status.clear_done  = (clr_addr_q == AW'(ATTRIBUTES - 1));
	assign status.emit_needed = (kind_q == KIND_TERM) && qend_q;
	assign status.emit_last   = (hits_q == '0) || (hits_rest == '0);

	assign match_id = match_id_q;
	assign found    = found_q;
	assign last     = last_q;

endmodule
`default_nettype wire

### design/bai_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bai_ctrl - controller of the bitmap attribute index
// Clearing pass, request sequencing, result emission and output valid.
// ----------------------------------------------------------------------------
module bai_ctrl
	import bai_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	output bai_cmd_t         cmd,
	input  wire bai_status_t status
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready       = (state_q == ST_IDLE);
	assign cmd.accept     = in_valid && in_ready;
	assign cmd.exec       = (state_q == ST_EXEC);
	assign cmd.clear_step = (state_q == ST_CLEAR);
	assign cmd.emit_load  = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign out_valid      = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (status.clear_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= status.emit_needed ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (cmd.emit_load && status.emit_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### design/bitmap_attribute_index.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_attribute_index - bitmap index with streamed boolean queries
// Per-attribute membership rows, set and clear requests, AND/OR queries
// over groups of terms, matching ids delivered in ascending order.
// ----------------------------------------------------------------------------
// After reset the block sweeps the row store once, one attribute per cycle,
// and takes no request until the sweep is done. Every set, clear or
// query-term request then passes through a row store read and then a
// combine or read-modify-write. A request that ends a query is followed by
// its results at one per cycle while the result channel is ready (one per
// match, or a single not-found result), and while the output register holds
// a result the next request is already taken.
module bitmap_attribute_index
	import bai_pkg::*;
#(
	parameter int VECTORS    = VECTORS_DEF,
	parameter int ATTRIBUTES = ATTRIBUTES_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	bai_item_if.sink    items,
	bai_result_if.source results
);

	bai_cmd_t    cmd;
	bai_status_t status;

	bai_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd),
		.status    (status)
	);

	bai_dp #(
		.VECTORS    (VECTORS),
		.ATTRIBUTES (ATTRIBUTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.kind      (items.kind),
		.vector_id (items.vector_id),
		.attribute (items.attribute),
		.or_inside (items.or_inside),
		.group_end (items.group_end),
		.query_end (items.query_end),
		.match_id  (results.match_id),
		.found     (results.found),
		.last      (results.last)
	);

endmodule
`default_nettype wire
